[rtl/ashit_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table of the annular sector hit test.
package ashit_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int COORD_BITS   = 16;

  localparam int CENTER_BITS   = COORD_BITS + 4;
  localparam int RADIUS_BITS   = COORD_BITS + 3;
  localparam int ANG_REG_BITS  = 16;
  localparam int DIFF_BITS     = CENTER_BITS + 1;
  localparam int SQ_BITS       = 2 * DIFF_BITS - 1;
  localparam int SUM_BITS      = SQ_BITS + 1;
  localparam int RSQ_BITS      = 2 * RADIUS_BITS;
  localparam int CW            = DIFF_BITS + 3;
  localparam int ZW            = 32;
  localparam int TABLE_LEN     = 24;
  localparam int CFG_DATA_BITS = (CENTER_BITS > ANG_REG_BITS) ? CENTER_BITS : ANG_REG_BITS;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [ZW-1:0] HALF_TURN   = {1'b1, {(ZW - 1){1'b0}}};
  localparam logic [ZW-1:0] ROUND_ADD   = ZW'(64'd1 << (ZW - 1 - ANGLE_BITS));
  localparam logic [ZW-1:0] ANGLE_MASK  = ZW'((64'd1 << ANGLE_BITS) - 64'd1);

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_ANGLE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_ANGLE    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_INNER_RADIUS = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTER_RADIUS = 3'd5;

  localparam logic [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic valid;
    logic zero;
    logic ring;
  } ashit_tag_t;

endpackage

[rtl/ashit_in_if.sv]
`timescale 1ns / 1ps
// Point input channel of the annular sector hit test.
interface ashit_in_if;
  logic valid;
  logic ready;
  logic signed [ashit_pkg::COORD_BITS-1:0] point_x;
  logic signed [ashit_pkg::COORD_BITS-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

[rtl/ashit_out_if.sv]
`timescale 1ns / 1ps
// Result channel of the annular sector hit test.
interface ashit_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic in_ring;
  logic in_sector;

  modport source (output valid, output hit, output in_ring, output in_sector, input ready);
  modport sink (input valid, input hit, input in_ring, input in_sector, output ready);
endinterface

[rtl/ashit_cfg_if.sv]
`timescale 1ns / 1ps
// Register write channel of the annular sector hit test.
interface ashit_cfg_if;
  logic valid;
  logic ready;
  logic [ashit_pkg::CFG_IDX_BITS-1:0] index;
  logic [ashit_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/ashit_cordic.sv]
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring unit, one rotation step per register stage.
module ashit_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  ashit_pkg::ashit_tag_t                in_tag,
  input  logic signed [ashit_pkg::CW-1:0]      in_x,
  input  logic signed [ashit_pkg::CW-1:0]      in_y,
  input  logic        [ashit_pkg::ZW-1:0]      in_z,
  output ashit_pkg::ashit_tag_t                out_tag,
  output logic        [ashit_pkg::ZW-1:0]      out_z
);

  ashit_pkg::ashit_tag_t           tag_r [ashit_pkg::CORDIC_STEPS];
  logic        [ashit_pkg::ZW-1:0] z_r   [ashit_pkg::CORDIC_STEPS];
  logic signed [ashit_pkg::CW-1:0] x_r   [ashit_pkg::CORDIC_STEPS-1];
  logic signed [ashit_pkg::CW-1:0] y_r   [ashit_pkg::CORDIC_STEPS-1];

  for (genvar k = 0; k < ashit_pkg::CORDIC_STEPS; k++) begin : g_step
    ashit_pkg::ashit_tag_t           ct;
    logic signed [ashit_pkg::CW-1:0] cx;
    logic signed [ashit_pkg::CW-1:0] cy;
    logic        [ashit_pkg::ZW-1:0] cz;
    logic signed [ashit_pkg::CW-1:0] xs;
    logic signed [ashit_pkg::CW-1:0] ys;
    logic                            up;

    if (k == 0) begin : g_first
      assign ct = in_tag;
      assign cx = in_x;
      assign cy = in_y;
      assign cz = in_z;
    end else begin : g_next
      assign ct = tag_r[k-1];
      assign cx = x_r[k-1];
      assign cy = y_r[k-1];
      assign cz = z_r[k-1];
    end

    assign xs = cx >>> k;
    assign ys = cy >>> k;
    assign up = !cy[ashit_pkg::CW-1] && (cy != '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else if (en) begin
        tag_r[k] <= ct;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[k] <= up ? cz + ashit_pkg::ATAN_TABLE[k] : cz - ashit_pkg::ATAN_TABLE[k];
      end
    end

    if (k < ashit_pkg::CORDIC_STEPS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k] <= up ? cx + ys : cx - ys;
          y_r[k] <= up ? cy - xs : cy + xs;
        end
      end
    end
  end

  assign out_tag = tag_r[ashit_pkg::CORDIC_STEPS-1];
  assign out_z   = z_r[ashit_pkg::CORDIC_STEPS-1];

endmodule

[rtl/annular_sector_hit_test_unit.sv]
`timescale 1ns / 1ps
// Top level of the annular sector hit test: registers, distance compare and angle check.
//
// Usage:
//   cfg_ch writes the six sector registers (center x/y, start/end angle,
//   inner/outer radius); it is always ready. The user must write it only while idle;
//   the block does not enforce it. in_ch carries one integer pixel point per
//   transfer; out_ch returns one result (hit, in_ring, in_sector) per point, in order.
// Pipeline: offset, squares and pre-rotation, ring compare, one CORDIC step
//   per stage, then angle rounding and the sector compare, each registered.
// Throughput: one point per cycle while out_ch is not stalled; the CORDIC
//   pipeline sets the depth, the squared-distance multipliers sit in stage B.
// Stall: when out_ch holds a result that is not taken, the whole pipeline
//   freezes and in_ch.ready drops; nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears all valid bits and returns
//   the six sector registers to zero.
module annular_sector_hit_test_unit (
  input  logic           clk,
  input  logic           rst_n,
  ashit_cfg_if.sink      cfg_ch,
  ashit_in_if.sink       in_ch,
  ashit_out_if.source    out_ch
);

  logic signed [ashit_pkg::CENTER_BITS-1:0]  center_x_r;
  logic signed [ashit_pkg::CENTER_BITS-1:0]  center_y_r;
  logic        [ashit_pkg::ANG_REG_BITS-1:0] start_angle_r;
  logic        [ashit_pkg::ANG_REG_BITS-1:0] end_angle_r;
  logic        [ashit_pkg::RADIUS_BITS-1:0]  inner_radius_r;
  logic        [ashit_pkg::RADIUS_BITS-1:0]  outer_radius_r;

  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      start_angle_r  <= '0;
      end_angle_r    <= '0;
      inner_radius_r <= '0;
      outer_radius_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ashit_pkg::REG_CENTER_X:     center_x_r     <= cfg_ch.data[ashit_pkg::CENTER_BITS-1:0];
        ashit_pkg::REG_CENTER_Y:     center_y_r     <= cfg_ch.data[ashit_pkg::CENTER_BITS-1:0];
        ashit_pkg::REG_START_ANGLE:  start_angle_r  <= cfg_ch.data[ashit_pkg::ANG_REG_BITS-1:0];
        ashit_pkg::REG_END_ANGLE:    end_angle_r    <= cfg_ch.data[ashit_pkg::ANG_REG_BITS-1:0];
        ashit_pkg::REG_INNER_RADIUS: inner_radius_r <= cfg_ch.data[ashit_pkg::RADIUS_BITS-1:0];
        ashit_pkg::REG_OUTER_RADIUS: outer_radius_r <= cfg_ch.data[ashit_pkg::RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Stage A: offset from the center in Q.4 pixels.
  logic                                    v_a_r;
  logic signed [ashit_pkg::DIFF_BITS-1:0]  dx_a_r;
  logic signed [ashit_pkg::DIFF_BITS-1:0]  dy_a_r;
  logic signed [ashit_pkg::DIFF_BITS-1:0]  px_ext;
  logic signed [ashit_pkg::DIFF_BITS-1:0]  py_ext;
  logic signed [ashit_pkg::DIFF_BITS-1:0]  cx_ext;
  logic signed [ashit_pkg::DIFF_BITS-1:0]  cy_ext;

  assign px_ext = {in_ch.point_x[ashit_pkg::COORD_BITS-1], in_ch.point_x, 4'b0000};
  assign py_ext = {in_ch.point_y[ashit_pkg::COORD_BITS-1], in_ch.point_y, 4'b0000};
  assign cx_ext = {center_x_r[ashit_pkg::CENTER_BITS-1], center_x_r};
  assign cy_ext = {center_y_r[ashit_pkg::CENTER_BITS-1], center_y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a_r <= px_ext - cx_ext;
      dy_a_r <= py_ext - cy_ext;
    end
  end

  // Stage B: squares and CORDIC pre-rotation into the right half plane.
  logic                                    v_b_r;
  logic                                    zero_b_r;
  logic        [ashit_pkg::SQ_BITS-1:0]    dx2_b_r;
  logic        [ashit_pkg::SQ_BITS-1:0]    dy2_b_r;
  logic        [ashit_pkg::RSQ_BITS-1:0]   ri2_b_r;
  logic        [ashit_pkg::RSQ_BITS-1:0]   ro2_b_r;
  logic signed [ashit_pkg::CW-1:0]         x_b_r;
  logic signed [ashit_pkg::CW-1:0]         y_b_r;
  logic        [ashit_pkg::ZW-1:0]         z_b_r;
  logic signed [2*ashit_pkg::DIFF_BITS-1:0] dx_prod;
  logic signed [2*ashit_pkg::DIFF_BITS-1:0] dy_prod;
  logic        [ashit_pkg::RSQ_BITS-1:0]   ri_prod;
  logic        [ashit_pkg::RSQ_BITS-1:0]   ro_prod;
  logic signed [ashit_pkg::CW-1:0]         dx_w;
  logic signed [ashit_pkg::CW-1:0]         dy_w;
  logic                                    neg_a;

  assign dx_prod = dx_a_r * dx_a_r;
  assign dy_prod = dy_a_r * dy_a_r;
  assign ri_prod = inner_radius_r * inner_radius_r;
  assign ro_prod = outer_radius_r * outer_radius_r;
  assign dx_w    = ashit_pkg::CW'(dx_a_r);
  assign dy_w    = ashit_pkg::CW'(dy_a_r);
  assign neg_a   = dx_a_r[ashit_pkg::DIFF_BITS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (en) begin
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_b_r  <= dx_prod[ashit_pkg::SQ_BITS-1:0];
      dy2_b_r  <= dy_prod[ashit_pkg::SQ_BITS-1:0];
      ri2_b_r  <= ri_prod;
      ro2_b_r  <= ro_prod;
      x_b_r    <= neg_a ? -dx_w : dx_w;
      y_b_r    <= neg_a ? -dy_w : dy_w;
      z_b_r    <= neg_a ? ashit_pkg::HALF_TURN : '0;
      zero_b_r <= (dx_a_r == '0) && (dy_a_r == '0);
    end
  end

  // Stage C: squared distance against the squared radii.
  ashit_pkg::ashit_tag_t                   tag_c_r;
  logic signed [ashit_pkg::CW-1:0]         x_c_r;
  logic signed [ashit_pkg::CW-1:0]         y_c_r;
  logic        [ashit_pkg::ZW-1:0]         z_c_r;
  logic        [ashit_pkg::SUM_BITS-1:0]   d2;
  logic        [ashit_pkg::SUM_BITS-1:0]   ri2_ext;
  logic        [ashit_pkg::SUM_BITS-1:0]   ro2_ext;

  assign d2      = ashit_pkg::SUM_BITS'(dx2_b_r) + ashit_pkg::SUM_BITS'(dy2_b_r);
  assign ri2_ext = ashit_pkg::SUM_BITS'(ri2_b_r);
  assign ro2_ext = ashit_pkg::SUM_BITS'(ro2_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_c_r <= '0;
    end else if (en) begin
      tag_c_r.valid <= v_b_r;
      tag_c_r.zero  <= zero_b_r;
      tag_c_r.ring  <= (d2 >= ri2_ext) && (d2 <= ro2_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_c_r <= x_b_r;
      y_c_r <= y_b_r;
      z_c_r <= z_b_r;
    end
  end

  ashit_pkg::ashit_tag_t           cordic_tag;
  logic [ashit_pkg::ZW-1:0]        cordic_z;

  ashit_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_tag  (tag_c_r),
    .in_x    (x_c_r),
    .in_y    (y_c_r),
    .in_z    (z_c_r),
    .out_tag (cordic_tag),
    .out_z   (cordic_z)
  );

  // Output stage: angle rounding and the sector compare.
  logic                            out_v_r;
  logic                            hit_r;
  logic                            in_ring_r;
  logic                            in_sector_r;
  logic [ashit_pkg::ZW-1:0]        z_round;
  logic [ashit_pkg::ZW-1:0]        ang;
  logic [ashit_pkg::ZW-1:0]        sa_m;
  logic [ashit_pkg::ZW-1:0]        ea_m;
  logic                            sect;

  assign z_round = cordic_z + ashit_pkg::ROUND_ADD;
  assign ang     = cordic_tag.zero ? '0
                 : ashit_pkg::ZW'(z_round[ashit_pkg::ZW-1 -: ashit_pkg::ANGLE_BITS]);
  assign sa_m    = ashit_pkg::ZW'(start_angle_r) & ashit_pkg::ANGLE_MASK;
  assign ea_m    = ashit_pkg::ZW'(end_angle_r) & ashit_pkg::ANGLE_MASK;
  assign sect    = (ang >= sa_m) && (ang <= ea_m);

  assign en = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= cordic_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r       <= cordic_tag.ring && sect;
      in_ring_r   <= cordic_tag.ring;
      in_sector_r <= sect;
    end
  end

  assign in_ch.ready      = en;
  assign out_ch.valid     = out_v_r;
  assign out_ch.hit       = hit_r;
  assign out_ch.in_ring   = in_ring_r;
  assign out_ch.in_sector = in_sector_r;

`ifndef NO_ASSERTIONS
  a_reset_clears_output: assert property (@(posedge clk) !rst_n |=> !out_v_r)
    else $error("output valid set right after reset");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(tag_c_r) && $stable(x_c_r) && $stable(z_c_r))
    else $error("pipeline stage changed during a stall");

  a_ring_needs_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && in_ring_r |-> inner_radius_r <= outer_radius_r)
    else $error("ring reported with inner radius above outer radius");

  a_sector_needs_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && in_sector_r |-> sa_m <= ea_m)
    else $error("sector reported with start angle above end angle");
`endif

endmodule

[sim/annular_sector_hit_test_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the annular sector hit test unit: directed table, random sectors.
module annular_sector_hit_test_unit_test;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_POINTS   = 500;
  localparam int SETTLE_CYCLES   = 40;
  localparam int LONG_HOLD       = 300;
  localparam int FILL_BURST      = 60;
  localparam int ERROR_PRINT_MAX = 20;

  localparam logic [ashit_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ashit_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [31:0] ARC_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic hit;
    logic in_ring;
    logic in_sector;
  } sector_flags_t;

  typedef enum logic {ROW_REG, ROW_POINT} row_kind_t;

  typedef struct {
    row_kind_t                                 kind;
    logic [ashit_pkg::CFG_IDX_BITS-1:0]        idx;
    logic [ashit_pkg::CFG_DATA_BITS-1:0]       data;
    logic signed [ashit_pkg::COORD_BITS-1:0]   px;
    logic signed [ashit_pkg::COORD_BITS-1:0]   py;
    bit                                        typed;
    sector_flags_t                             want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ashit_cfg_if cfg_ch ();
  ashit_in_if  in_ch ();
  ashit_out_if out_ch ();

  annular_sector_hit_test_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [ashit_pkg::CENTER_BITS-1:0] sec_cx = '0;
  logic signed [ashit_pkg::CENTER_BITS-1:0] sec_cy = '0;
  logic [ashit_pkg::ANG_REG_BITS-1:0]       sec_start = '0;
  logic [ashit_pkg::ANG_REG_BITS-1:0]       sec_end = '0;
  logic [ashit_pkg::RADIUS_BITS-1:0]        sec_rin = '0;
  logic [ashit_pkg::RADIUS_BITS-1:0]        sec_rout = '0;

  sector_flags_t flags_pending_q[$];

  int  fail_count = 0;
  int  points_sent = 0;
  int  results_seen = 0;
  int  setting_count = 0;
  int  hit_total = 0;
  int  ring_total = 0;
  int  sector_total = 0;
  int  cycle_count = 0;
  bit  long_hold_done = 1'b0;
  bit  hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sector_flags_t predict_sector_flags(
      logic signed [ashit_pkg::COORD_BITS-1:0] px,
      logic signed [ashit_pkg::COORD_BITS-1:0] py);
    longint dx, dy, d2, x, y, xs, ys;
    logic [31:0] z;
    logic [32:0] zr;
    logic [ashit_pkg::ANGLE_BITS-1:0] ang;
    sector_flags_t r;
    dx = longint'(px) * 16 - longint'(sec_cx);
    dy = longint'(py) * 16 - longint'(sec_cy);
    d2 = dx * dx + dy * dy;
    x = dx;
    y = dy;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < ashit_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARC_TURNS[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARC_TURNS[i];
      end
    end
    zr = {1'b0, z} + (33'd1 << (31 - ashit_pkg::ANGLE_BITS));
    ang = (dx == 0 && dy == 0) ? '0 : zr[31 -: ashit_pkg::ANGLE_BITS];
    r.in_ring = (d2 >= longint'(sec_rin) * longint'(sec_rin)) &&
                (d2 <= longint'(sec_rout) * longint'(sec_rout));
    r.in_sector = (ang >= sec_start) && (ang <= sec_end);
    r.hit = r.in_ring && r.in_sector;
    return r;
  endfunction

  function automatic void apply_reg(logic [ashit_pkg::CFG_IDX_BITS-1:0] idx,
                                    logic [ashit_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      ashit_pkg::REG_CENTER_X:     sec_cx = data[ashit_pkg::CENTER_BITS-1:0];
      ashit_pkg::REG_CENTER_Y:     sec_cy = data[ashit_pkg::CENTER_BITS-1:0];
      ashit_pkg::REG_START_ANGLE:  sec_start = data[ashit_pkg::ANG_REG_BITS-1:0];
      ashit_pkg::REG_END_ANGLE:    sec_end = data[ashit_pkg::ANG_REG_BITS-1:0];
      ashit_pkg::REG_INNER_RADIUS: sec_rin = data[ashit_pkg::RADIUS_BITS-1:0];
      ashit_pkg::REG_OUTER_RADIUS: sec_rout = data[ashit_pkg::RADIUS_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic stim_row_t reg_row(logic [ashit_pkg::CFG_IDX_BITS-1:0] idx,
                                        logic [ashit_pkg::CFG_DATA_BITS-1:0] data);
    stim_row_t r;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data;
    r.px = '0;
    r.py = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t point_row(logic signed [ashit_pkg::COORD_BITS-1:0] px,
                                          logic signed [ashit_pkg::COORD_BITS-1:0] py);
    stim_row_t r;
    r = reg_row(ashit_pkg::REG_CENTER_X, '0);
    r.kind = ROW_POINT;
    r.px = px;
    r.py = py;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic signed [ashit_pkg::COORD_BITS-1:0] px,
                                          logic signed [ashit_pkg::COORD_BITS-1:0] py,
                                          sector_flags_t want);
    stim_row_t r;
    r = point_row(px, py);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [ashit_pkg::COORD_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return -16'sh0001;
    endcase
  endfunction

  function automatic logic [ashit_pkg::CFG_DATA_BITS-1:0] pick_center();
    case ($urandom_range(0, 3))
      0: return ashit_pkg::CFG_DATA_BITS'($urandom);
      1: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
      2: return ashit_pkg::CFG_DATA_BITS'(($urandom_range(0, 4000) - 2000) * 16);
      default: return ashit_pkg::CFG_DATA_BITS'(($urandom_range(0, 4000) - 2000) * 16 +
                                                $urandom_range(0, 15));
    endcase
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= ERROR_PRINT_MAX)
        $display("%0d ns: result %0d %s expected %0b actual %0b",
                 $time, results_seen, name, want, got);
    end
  endfunction

  function automatic void check_result(sector_flags_t got);
    sector_flags_t want;
    results_seen++;
    hit_total += got.hit;
    ring_total += got.in_ring;
    sector_total += got.in_sector;
    if (flags_pending_q.size() == 0) begin
      fail_count++;
      if (fail_count <= ERROR_PRINT_MAX)
        $display("%0d ns: expected no result, actual hit %0b in_ring %0b in_sector %0b",
                 $time, got.hit, got.in_ring, got.in_sector);
      return;
    end
    want = flags_pending_q.pop_front();
    check_field("hit", want.hit, got.hit);
    check_field("in_ring", want.in_ring, got.in_ring);
    check_field("in_sector", want.in_sector, got.in_sector);
  endfunction

  task automatic put_reg(logic [ashit_pkg::CFG_IDX_BITS-1:0] idx,
                         logic [ashit_pkg::CFG_DATA_BITS-1:0] data, bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, data);
    if (last) begin
      cfg_ch.valid <= 1'b0;
      setting_count++;
    end
  endtask

  task automatic send_point(logic signed [ashit_pkg::COORD_BITS-1:0] px,
                            logic signed [ashit_pkg::COORD_BITS-1:0] py,
                            sector_flags_t want, int gap);
    in_ch.valid <= 1'b1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    do @(posedge clk); while (!in_ch.ready);
    flags_pending_q.push_back(want);
    points_sent++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (flags_pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic new_random_setting();
    logic [ashit_pkg::CFG_DATA_BITS-1:0] sa, ea, ri, ro;
    case ($urandom_range(0, 3))
      0: begin
        sa = ashit_pkg::CFG_DATA_BITS'($urandom);
        ea = ashit_pkg::CFG_DATA_BITS'($urandom);
      end
      1: begin
        sa = {4'($urandom), 16'h0000};
        ea = {4'($urandom), 16'hFFFF};
      end
      2: begin
        sa = ashit_pkg::CFG_DATA_BITS'($urandom);
        ea = {4'($urandom), sa[15:0]};
      end
      default: begin
        sa = ashit_pkg::CFG_DATA_BITS'($urandom_range(0, 49151));
        ea = sa + ashit_pkg::CFG_DATA_BITS'($urandom_range(0, 16383));
      end
    endcase
    case ($urandom_range(0, 4))
      0: begin
        ri = '0;
        ro = ashit_pkg::CFG_DATA_BITS'($urandom_range(0, 16 * 600));
      end
      1: begin
        ri = ashit_pkg::CFG_DATA_BITS'($urandom_range(0, 16 * 300));
        ro = ri + ashit_pkg::CFG_DATA_BITS'($urandom_range(0, 16 * 300));
      end
      2: begin
        ri = ashit_pkg::CFG_DATA_BITS'($urandom);
        ro = ashit_pkg::CFG_DATA_BITS'($urandom);
      end
      3: begin
        ri = '0;
        ro = $urandom_range(0, 1) ? 20'hFFFFF : 20'h7FFFF;
      end
      default: begin
        ri = ashit_pkg::CFG_DATA_BITS'($urandom_range(16 * 50, 16 * 400));
        ro = ri - ashit_pkg::CFG_DATA_BITS'($urandom_range(1, 16 * 50));
      end
    endcase
    if ($urandom_range(0, 4) == 0)
      put_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
              ashit_pkg::CFG_DATA_BITS'($urandom), 1'b0);
    put_reg(ashit_pkg::REG_CENTER_X, pick_center(), 1'b0);
    put_reg(ashit_pkg::REG_CENTER_Y, pick_center(), 1'b0);
    put_reg(ashit_pkg::REG_START_ANGLE, sa, 1'b0);
    put_reg(ashit_pkg::REG_END_ANGLE, ea, 1'b0);
    put_reg(ashit_pkg::REG_INNER_RADIUS, ri, 1'b0);
    put_reg(ashit_pkg::REG_OUTER_RADIUS, ro, 1'b1);
  endtask

  task automatic pick_point(output logic signed [ashit_pkg::COORD_BITS-1:0] px,
                            output logic signed [ashit_pkg::COORD_BITS-1:0] py);
    int cxp, cyp, span, sel;
    cxp = int'(sec_cx) >>> 4;
    cyp = int'(sec_cy) >>> 4;
    span = int'(sec_rout >> 4) + 8;
    if (span > 40000) span = 40000;
    sel = $urandom_range(0, 9);
    px = ashit_pkg::COORD_BITS'(cxp - span + int'($urandom_range(0, 2 * span)));
    py = ashit_pkg::COORD_BITS'(cyp - span + int'($urandom_range(0, 2 * span)));
    if (sel == 6 || sel == 7) begin
      px = ashit_pkg::COORD_BITS'($urandom);
      py = ashit_pkg::COORD_BITS'($urandom);
    end else if (sel == 8) begin
      px = pick_extreme();
      py = pick_extreme();
    end else if (sel == 9) begin
      if ($urandom_range(0, 1)) px = ashit_pkg::COORD_BITS'(cxp);
      else py = ashit_pkg::COORD_BITS'(cyp);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timed out after %0d cycles with %0d results pending",
                 cycle_count, flags_pending_q.size());
        $display("annular_sector_hit_test_unit_test failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    int calm;
    sector_flags_t got;
    calm = 0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!long_hold_done && hold_request) begin
        long_hold_done = 1'b1;
        stall = LONG_HOLD;
      end else if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = pick_idle();
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.hit = out_ch.hit;
      got.in_ring = out_ch.in_ring;
      got.in_sector = out_ch.in_sector;
      check_result(got);
    end
  end

  initial begin
    stim_row_t directed_q[$];
    stim_row_t row;
    logic signed [ashit_pkg::COORD_BITS-1:0] px, py;
    sector_flags_t want;
    int n, target;
    bit burst;
    bit first;
    rst_n <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;

    // Expected flags are written as {hit, in_ring, in_sector}.
    directed_q.push_back(known_row(16'sd0, 16'sd0, 3'b111));
    directed_q.push_back(point_row(16'sh7FFF, 16'sh7FFF));
    directed_q.push_back(point_row(16'sh8000, 16'sh8000));
    directed_q.push_back(point_row(16'sd1, 16'sd0));
    directed_q.push_back(point_row(-16'sd1, 16'sd0));
    directed_q.push_back(point_row(16'sd0, -16'sd1));
    directed_q.push_back(reg_row(ashit_pkg::REG_CENTER_X, 20'h7FFFF));
    directed_q.push_back(reg_row(ashit_pkg::REG_CENTER_Y, 20'h80000));
    directed_q.push_back(reg_row(ashit_pkg::REG_START_ANGLE, 20'h00000));
    directed_q.push_back(reg_row(ashit_pkg::REG_END_ANGLE, 20'h0FFFF));
    directed_q.push_back(reg_row(ashit_pkg::REG_INNER_RADIUS, 20'h00000));
    directed_q.push_back(reg_row(ashit_pkg::REG_OUTER_RADIUS, 20'h7FFFF));
    directed_q.push_back(known_row(16'sh7FFF, 16'sh8000, 3'b111));
    directed_q.push_back(known_row(16'sh8000, 16'sh7FFF, 3'b001));
    directed_q.push_back(known_row(16'sd0, 16'sd0, 3'b001));
    directed_q.push_back(point_row(-16'sd1, 16'sh8000));
    directed_q.push_back(reg_row(REG_SPARE_LO, 20'hABCDE));
    directed_q.push_back(reg_row(ashit_pkg::REG_START_ANGLE, 20'hF8000));
    directed_q.push_back(reg_row(ashit_pkg::REG_END_ANGLE, 20'h57FFF));
    directed_q.push_back(reg_row(ashit_pkg::REG_INNER_RADIUS, 20'hFFFFF));
    directed_q.push_back(reg_row(ashit_pkg::REG_OUTER_RADIUS, 20'h80000));
    directed_q.push_back(reg_row(REG_SPARE_HI, 20'h7FFFF));
    directed_q.push_back(known_row(16'sd0, 16'sd0, 3'b000));
    directed_q.push_back(known_row(16'sd100, -16'sd100, 3'b000));
    directed_q.push_back(known_row(16'sh8000, 16'sh8000, 3'b000));
    directed_q.push_back(reg_row(ashit_pkg::REG_CENTER_X, 20'h00000));
    directed_q.push_back(reg_row(ashit_pkg::REG_CENTER_Y, 20'h00000));
    directed_q.push_back(reg_row(ashit_pkg::REG_START_ANGLE, 20'h00000));
    directed_q.push_back(reg_row(ashit_pkg::REG_END_ANGLE, 20'h00000));
    directed_q.push_back(reg_row(ashit_pkg::REG_INNER_RADIUS, 20'h00000));
    directed_q.push_back(reg_row(ashit_pkg::REG_OUTER_RADIUS, 20'd160));
    directed_q.push_back(known_row(16'sd0, 16'sd0, 3'b111));
    directed_q.push_back(point_row(16'sd10, 16'sd0));
    directed_q.push_back(point_row(16'sd0, -16'sd10));
    directed_q.push_back(point_row(-16'sd10, 16'sd0));
    directed_q.push_back(point_row(16'sd7, -16'sd7));
    directed_q.push_back(point_row(16'sd8, -16'sd8));
    directed_q.push_back(point_row(16'sh7FFF, -16'sd1));
    directed_q.push_back(reg_row(ashit_pkg::REG_START_ANGLE, 20'h04000));
    directed_q.push_back(reg_row(ashit_pkg::REG_END_ANGLE, 20'h0C000));
    directed_q.push_back(reg_row(ashit_pkg::REG_INNER_RADIUS, 20'd80));
    directed_q.push_back(reg_row(ashit_pkg::REG_OUTER_RADIUS, 20'd320));
    directed_q.push_back(point_row(-16'sd10, 16'sd0));
    directed_q.push_back(point_row(16'sd0, 16'sd10));
    directed_q.push_back(point_row(16'sd0, -16'sd10));
    directed_q.push_back(point_row(16'sd3, 16'sd0));
    directed_q.push_back(point_row(16'sd10, 16'sd10));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < directed_q.size(); k++) begin
      row = directed_q[k];
      if (row.kind == ROW_REG) begin
        if (k == 0 || directed_q[k-1].kind != ROW_REG) wait_idle();
        put_reg(row.idx, row.data,
                k + 1 == directed_q.size() || directed_q[k+1].kind != ROW_REG);
      end else begin
        want = row.typed ? row.want : predict_sector_flags(row.px, row.py);
        send_point(row.px, row.py, want, pick_idle());
      end
    end

    // The first random setting is sent as one long burst while the receiver holds off.
    first = 1'b1;
    target = points_sent + RANDOM_POINTS;
    while (points_sent < target) begin
      wait_idle();
      new_random_setting();
      n = first ? FILL_BURST : $urandom_range(15, 50);
      burst = first || ($urandom_range(0, 3) == 0);
      if (first) hold_request = 1'b1;
      first = 1'b0;
      repeat (n) begin
        pick_point(px, py);
        send_point(px, py, predict_sector_flags(px, py), burst ? 0 : pick_idle());
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d points under %0d sector settings in %0d cycles.",
             results_seen, setting_count, cycle_count);
    $display("Results seen: %0d hits, %0d inside the ring, %0d inside the angle range.",
             hit_total, ring_total, sector_total);
    if (fail_count == 0)
      $display("annular_sector_hit_test_unit_test passed");
    else
      $display("annular_sector_hit_test_unit_test failed");
    $finish;
  end

endmodule

[sim.f]
rtl/ashit_pkg.sv
rtl/ashit_in_if.sv
rtl/ashit_out_if.sv
rtl/ashit_cfg_if.sv
rtl/ashit_cordic.sv
rtl/annular_sector_hit_test_unit.sv
sim/annular_sector_hit_test_unit_test.sv
